[src/mfq_pkg.sv]
// Package for the mbox "From " quoting filter.
// Holds line phase codes, character constants, the prefix table and the shared types.
// No dependencies.
package mfq_pkg;

  localparam logic [1:0] PH_START = 2'd0;  // at line start
  localparam logic [1:0] PH_DOT   = 2'd1;  // dot held at line start
  localparam logic [1:0] PH_FROM  = 2'd2;  // partial "From " held
  localparam logic [1:0] PH_MID   = 2'd3;  // inside a line

  localparam logic [7:0] NL_CH    = 8'h0A;
  localparam logic [7:0] DOT_CH   = 8'h2E;
  localparam logic [7:0] QUOTE_CH = 8'h3E;

  localparam logic [2:0] MARK_LEN  = 3'd5;
  localparam logic [2:0] HELD_MAX  = 3'd4;
  localparam int         BURST_MAX = 6;

  // Line filter state
  typedef struct packed {
    logic [1:0] phase;
    logic [2:0] match_len;
    logic       blank;
  } mfq_state_t;

  // Bytes one input byte turns into
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      is_end;  // burst closes the letter
    logic                      by_dot;  // closed by a lone dot line
  } mfq_burst_t;

  // "From " character at a given position
  function automatic logic [7:0] mark_byte(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h46;
      3'd1:    ch = 8'h72;
      3'd2:    ch = 8'h6F;
      3'd3:    ch = 8'h6D;
      3'd4:    ch = 8'h20;
      default: ch = 8'h20;
    endcase
    return ch;
  endfunction

endpackage

[src/mfq_if.sv]
// Valid/ready channel interfaces for the quoting filter.
// mfq_in_if carries input bytes, mfq_out_if carries filtered bytes. No dependencies.
interface mfq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_marker;

  modport source (output valid, output in_byte, output end_marker, input ready);
  modport sink   (input valid, input in_byte, input end_marker, output ready);
endinterface

interface mfq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       dot_ended;

  modport source (output valid, output out_byte, output last, output dot_ended,
                  input ready);
  modport sink   (input valid, input out_byte, input last, input dot_ended,
                  output ready);
endinterface

[src/mbox_from_quoting_filter_top.sv]
// Top level of the mbox "From " quoting filter with lone-dot letter terminator.
// Depends on mfq_pkg, mfq_if, mfq_step and mfq_burst_buf.
//
//  channel  | dir | payload                         | transfer when
//  ---------+-----+---------------------------------+--------------------
//  in_ch    | in  | in_byte[7:0], end_marker        | valid && ready
//  out_ch   | out | out_byte[7:0], last, dot_ended  | valid && ready
//
// One input transfer per cycle while out_ch is ready and bursts hold at most one
// byte; each input byte yields a burst of 0..6 output bytes held in a burst register
// and sent one per cycle while out_ch is ready, and input waits until it drains.
// in_ch.ready is high when the burst register is empty or about to send its
// final byte; a stalled out_ch holds the current byte and blocks new input.
// rst_n (synchronous) returns the filter to line start and empties the burst.
module mbox_from_quoting_filter_top
  import mfq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mfq_in_if.sink    in_ch,
  mfq_out_if.source out_ch
);

  mfq_state_t state_r, state_nxt;
  mfq_state_t step_nxt;
  mfq_burst_t burst;
  logic       can_load;
  logic       in_fire;

  assign in_ch.ready = can_load;
  assign in_fire     = in_ch.valid && can_load;

  // Line filter decision for the offered byte
  mfq_step u_step (
    .cur        (state_r),
    .in_byte    (in_ch.in_byte),
    .end_marker (in_ch.end_marker),
    .nxt        (step_nxt),
    .burst      (burst)
  );

  // Line state advances only on an input transfer
  assign state_nxt = in_fire ? step_nxt : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  mfq_burst_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .burst     (burst),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last),
    .out_dot   (out_ch.dot_ended)
  );

endmodule

[src/mfq_step.sv]
// Per-byte filter step: next line state and the burst of output bytes.
// Depends on mfq_pkg.
module mfq_step
  import mfq_pkg::*;
(
  input  mfq_state_t cur,
  input  logic [7:0] in_byte,
  input  logic       end_marker,
  output mfq_state_t nxt,
  output mfq_burst_t burst
);

  logic [2:0] held;      // prefix bytes to flush, clamped to four
  logic       blank_eff;
  logic       match_ok;

  always_comb begin
    held      = cur.match_len[2] ? HELD_MAX : cur.match_len;
    blank_eff = (cur.phase == PH_FROM) ? 1'b0 : cur.blank;
    match_ok  = (cur.match_len < MARK_LEN) && (in_byte == mark_byte(cur.match_len));

    nxt          = cur;
    burst.bytes  = '0;
    burst.count  = 3'd0;
    burst.is_end = 1'b0;
    burst.by_dot = 1'b0;

    if (end_marker) begin
      // flushed prefix, then the closing newlines
      for (int i = 0; i < BURST_MAX; i++) begin
        burst.bytes[i] = (3'(i) < held && cur.phase == PH_FROM) ? mark_byte(3'(i)) : NL_CH;
      end
      burst.count  = ((cur.phase == PH_FROM) ? held : 3'd0)
                   + {2'b0, cur.phase != PH_START} + {2'b0, !blank_eff};
      burst.is_end = 1'b1;
      nxt          = '0;
    end else begin
      case (cur.phase)
        PH_START: begin
          if (in_byte == DOT_CH) begin
            nxt.phase = PH_DOT;
          end else if (in_byte == mark_byte(3'd0)) begin
            nxt.phase     = PH_FROM;
            nxt.match_len = 3'd1;
          end else begin
            burst.bytes[0] = in_byte;
            burst.count    = 3'd1;
            if (in_byte == NL_CH) begin
              nxt.blank = 1'b1;
            end else begin
              nxt.blank = 1'b0;
              nxt.phase = PH_MID;
            end
          end
        end
        PH_DOT: begin
          if (in_byte == NL_CH) begin
            // lone dot line ends the letter
            burst.bytes[0] = NL_CH;
            burst.count    = {2'b0, !cur.blank};
            burst.is_end   = 1'b1;
            burst.by_dot   = 1'b1;
            nxt            = '0;
          end else begin
            burst.bytes[0] = DOT_CH;
            burst.bytes[1] = in_byte;
            burst.count    = 3'd2;
            nxt.blank      = 1'b0;
            nxt.phase      = PH_MID;
          end
        end
        PH_FROM: begin
          if (match_ok) begin
            nxt.match_len = cur.match_len + 3'd1;
            if (cur.match_len == HELD_MAX) begin
              burst.bytes[0] = QUOTE_CH;
              for (int i = 1; i < BURST_MAX; i++) begin
                burst.bytes[i] = mark_byte(3'(i - 1));
              end
              burst.count   = 3'd6;
              nxt.match_len = 3'd0;
              nxt.blank     = 1'b0;
              nxt.phase     = PH_MID;
            end
          end else begin
            // mismatch: flush held prefix, then the byte
            for (int i = 0; i < BURST_MAX; i++) begin
              burst.bytes[i] = (3'(i) < held) ? mark_byte(3'(i)) : in_byte;
            end
            burst.count   = held + 3'd1;
            nxt.match_len = 3'd0;
            nxt.blank     = 1'b0;
            nxt.phase     = (in_byte == NL_CH) ? PH_START : PH_MID;
          end
        end
        default: begin
          burst.bytes[0] = in_byte;
          burst.count    = 3'd1;
          if (in_byte == NL_CH) nxt.phase = PH_START;
        end
      endcase
    end
  end

endmodule

[src/mfq_burst_buf.sv]
// Burst register and serializer: holds up to six bytes, sends one per transfer.
// Depends on mfq_pkg.
module mfq_burst_buf
  import mfq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,       // input transfer this cycle
  input  mfq_burst_t burst,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_dot
);

  logic [BURST_MAX-1:0][7:0] buf_r, buf_nxt;
  logic [2:0]                rem_r, rem_nxt;
  logic                      end_r, end_nxt;
  logic                      dot_r, dot_nxt;
  logic                      out_fire;

  assign out_valid = (rem_r != 3'd0);
  assign out_fire  = out_valid && out_ready;
  assign can_load  = (rem_r == 3'd0) || (rem_r == 3'd1 && out_ready);
  assign out_byte  = buf_r[0];
  assign out_last  = end_r && (rem_r == 3'd1);
  assign out_dot   = dot_r && (rem_r == 3'd1);

  always_comb begin
    buf_nxt = buf_r;
    rem_nxt = rem_r;
    end_nxt = end_r;
    dot_nxt = dot_r;
    if (load) begin
      buf_nxt = burst.bytes;
      rem_nxt = burst.count;
      end_nxt = burst.is_end;
      dot_nxt = burst.by_dot;
    end else if (out_fire) begin
      for (int i = 0; i < BURST_MAX - 1; i++) begin
        buf_nxt[i] = buf_r[i + 1];
      end
      rem_nxt = rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    end_r <= end_nxt;
    dot_r <= dot_nxt;
    if (!rst_n) begin
      rem_r <= 3'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule
